// ===== hw/rtl/rrpm_pkg.sv =====
package rrpm_pkg;

    localparam int unsigned MAX_NODES_DEFAULT = 8;

    localparam logic [15:0] POLL_INTERVAL_RESET = 16'd1000;
    localparam logic [15:0] RESPONSE_TIMEOUT_RESET = 16'd200;
    localparam logic [3:0]  NODE_COUNT_RESET = 4'd0;
    localparam logic [63:0] NODE_ID_TABLE_RESET = 64'd0;
    localparam logic [7:0]  PRESSURE_MASK_RESET = 8'd1;

    localparam logic signed [15:0] TEMP_MIN = -16'sd4000;
    localparam logic signed [15:0] TEMP_MAX = 16'sd8500;
    localparam logic [15:0] HUM_MAX = 16'd10000;
    localparam logic [16:0] PRES_MIN = 17'd30000;
    localparam logic [16:0] PRES_MAX = 17'd110000;

    typedef enum logic [2:0] {
        CFG_POLL_INTERVAL    = 3'd0,
        CFG_RESPONSE_TIMEOUT = 3'd1,
        CFG_NODE_COUNT       = 3'd2,
        CFG_NODE_ID_TABLE    = 3'd3,
        CFG_PRESSURE_MASK    = 3'd4
    } rrpm_cfg_index_t;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_SENT        = 4'd1,
        EV_ACCEPTED    = 4'd2,
        EV_NOT_WAITING = 4'd3,
        EV_WRONG_NODE  = 4'd4,
        EV_SEQ_MISMATCH = 4'd5,
        EV_BAD_TEMP    = 4'd6,
        EV_BAD_HUMIDITY = 4'd7,
        EV_BAD_PRESSURE = 4'd8,
        EV_TIMEOUT     = 4'd9,
        EV_TX_ERROR    = 4'd10
    } rrpm_event_t;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    typedef struct packed {
        logic               op;
        logic               tx_ok;
        logic [7:0]         reply_node;
        logic [15:0]        reply_sequence;
        logic [7:0]         reply_flags;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
        logic [16:0]        pressure;
    } rrpm_in_t;

    typedef struct packed {
        rrpm_event_t event_res;
        logic [7:0]  node_id;
        logic [15:0] sequence_res;
        logic [15:0] response_time;
        logic [7:0]  online_map;
        logic [2:0]  node_index;
    } rrpm_out_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } rrpm_find_t;

    // First registered table entry that holds the given id.
    function automatic rrpm_find_t rrpm_find_id(
        input logic [63:0] id_table,
        input logic [3:0]  active_cnt,
        input logic [7:0]  id
    );
        rrpm_find_t res;
        res.hit = 1'b0;
        res.idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if ((4'(i) < active_cnt) && (id_table[i*8 +: 8] == id))
            begin
                res.hit = 1'b1;
                res.idx = 3'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/rrpm_ifs.sv =====
interface rrpm_in_if import rrpm_pkg::*; ();
    logic     valid;
    logic     ready;
    rrpm_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrpm_out_if import rrpm_pkg::*; ();
    logic      valid;
    logic      ready;
    rrpm_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrpm_cfg_if import rrpm_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/round_robin_poll_master_unit.sv =====
// Round-robin polling master with response timeout.
// The cmd channel carries one event per transfer: a one-millisecond tick
// (op low, with tx_ok telling whether the radio took a pending request) or
// a sensor reply with its node id, sequence and readings. Every cmd transfer
// yields exactly one evt transfer that reports what happened, the polled
// index and the online map after the event.
// The cfg channel writes the five setup registers by index; it is always
// ready and is meant to be used only while no event is in flight.
// A cmd transfer lands in an input register; the polling logic then
// updates its state and loads the evt result register, which offers the
// result. One event per cycle is sustained while the evt receiver does
// not stall, set by the single pass of compares and counter updates
// between the input register and the result register.
// When the evt receiver stalls, the result is held and the input register
// still takes one more cmd transfer; cmd ready then drops until the result
// moves. Reset clears the state, loads the register defaults and leaves
// both channels empty.
module round_robin_poll_master_unit
    import rrpm_pkg::*;
#(
    parameter int unsigned MAX_NODES = MAX_NODES_DEFAULT
)
(
    input logic         clk,
    input logic         rst_n,
    rrpm_in_if.sink     cmd,
    rrpm_out_if.source  evt,
    rrpm_cfg_if.sink    cfg
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_WAIT
    } phase_t;

    localparam logic [3:0] MAX_CNT = 4'(MAX_NODES);

    logic [15:0] poll_interval_reg;
    logic [15:0] response_timeout_reg;
    logic [3:0]  node_count_reg;
    logic [63:0] node_id_table_reg;
    logic [7:0]  pressure_mask_reg;

    phase_t      phase_reg, phase_next;
    logic [2:0]  current_index_reg, current_index_next;
    logic [15:0] seq_counter_reg, seq_counter_next;
    logic [15:0] expected_seq_reg, expected_seq_next;
    logic [31:0] time_now_reg, time_now_next;
    logic [31:0] idle_stamp_reg, idle_stamp_next;
    logic [31:0] request_stamp_reg, request_stamp_next;
    logic [7:0]  online_reg, online_next;

    logic        inq_valid_reg;
    rrpm_in_t    inq_reg;
    logic        res_valid_reg;
    rrpm_out_t   res_reg, res_next;

    logic        step;
    logic [3:0]  active_cnt;
    logic        cur_valid;
    logic [7:0]  cur_id;
    logic [3:0]  index_inc;
    logic [2:0]  adv_index;
    logic [31:0] time_inc;
    logic [31:0] idle_elapsed;
    logic [31:0] wait_elapsed;
    logic [31:0] reply_elapsed;
    logic [15:0] seq_inc;
    rrpm_find_t  cur_find;
    rrpm_find_t  reply_find;

    assign step = inq_valid_reg && (!res_valid_reg || evt.ready);
    assign cmd.ready = !inq_valid_reg || step;
    assign cfg.ready = 1'b1;
    assign evt.valid = res_valid_reg;
    assign evt.data = res_reg;

    assign active_cnt = (node_count_reg > MAX_CNT) ? MAX_CNT : node_count_reg;
    assign cur_valid = {1'b0, current_index_reg} < active_cnt;
    assign cur_id = node_id_table_reg[{current_index_reg, 3'b000} +: 8];
    assign index_inc = {1'b0, current_index_reg} + 4'd1;
    assign adv_index = (index_inc >= active_cnt) ? 3'd0 : index_inc[2:0];
    assign time_inc = time_now_reg + 32'd1;
    assign idle_elapsed = time_inc - idle_stamp_reg;
    assign wait_elapsed = time_inc - request_stamp_reg;
    assign reply_elapsed = time_now_reg - request_stamp_reg;
    assign seq_inc = seq_counter_reg + 16'd1;
    assign cur_find = rrpm_find_id(node_id_table_reg, active_cnt, cur_id);
    assign reply_find = rrpm_find_id(node_id_table_reg, active_cnt, inq_reg.reply_node);

    always_comb
    begin
        phase_next = phase_reg;
        current_index_next = current_index_reg;
        seq_counter_next = seq_counter_reg;
        expected_seq_next = expected_seq_reg;
        time_now_next = time_now_reg;
        idle_stamp_next = idle_stamp_reg;
        request_stamp_next = request_stamp_reg;
        online_next = online_reg;
        res_next = '0;
        res_next.event_res = EV_NONE;

        if (inq_reg.op == OP_TICK)
        begin
            time_now_next = time_inc;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (idle_elapsed >= {16'd0, poll_interval_reg})
                    begin
                        phase_next = PH_SEND;
                    end
                end
                PH_SEND:
                begin
                    if (!cur_valid)
                    begin
                        current_index_next = adv_index;
                        idle_stamp_next = time_inc;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res_next.node_id = cur_id;
                        res_next.sequence_res = seq_inc;
                        seq_counter_next = seq_inc;
                        expected_seq_next = seq_inc;
                        if (!inq_reg.tx_ok)
                        begin
                            if (cur_find.hit)
                            begin
                                online_next[cur_find.idx] = 1'b0;
                            end
                            current_index_next = adv_index;
                            idle_stamp_next = time_inc;
                            phase_next = PH_IDLE;
                            res_next.event_res = EV_TX_ERROR;
                        end
                        else
                        begin
                            request_stamp_next = time_inc;
                            phase_next = PH_WAIT;
                            res_next.event_res = EV_SENT;
                        end
                    end
                end
                PH_WAIT:
                begin
                    if (wait_elapsed >= {16'd0, response_timeout_reg})
                    begin
                        res_next.sequence_res = expected_seq_reg;
                        if (cur_valid)
                        begin
                            res_next.node_id = cur_id;
                            if (cur_find.hit)
                            begin
                                online_next[cur_find.idx] = 1'b0;
                            end
                        end
                        current_index_next = adv_index;
                        idle_stamp_next = time_inc;
                        phase_next = PH_IDLE;
                        res_next.event_res = EV_TIMEOUT;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else
        begin
            res_next.node_id = inq_reg.reply_node;
            res_next.sequence_res = expected_seq_reg;
            if (phase_reg != PH_WAIT)
            begin
                res_next.event_res = EV_NOT_WAITING;
            end
            else if (!reply_find.hit || !cur_valid || (cur_id != inq_reg.reply_node))
            begin
                res_next.event_res = EV_WRONG_NODE;
            end
            else if (inq_reg.reply_sequence != expected_seq_reg)
            begin
                res_next.event_res = EV_SEQ_MISMATCH;
            end
            else if ((inq_reg.temperature < TEMP_MIN) || (inq_reg.temperature > TEMP_MAX))
            begin
                res_next.event_res = EV_BAD_TEMP;
            end
            else if (inq_reg.humidity > HUM_MAX)
            begin
                res_next.event_res = EV_BAD_HUMIDITY;
            end
            else if (((inq_reg.reply_flags & pressure_mask_reg) != 8'd0)
                     && ((inq_reg.pressure < PRES_MIN) || (inq_reg.pressure > PRES_MAX)))
            begin
                res_next.event_res = EV_BAD_PRESSURE;
            end
            else
            begin
                online_next[reply_find.idx] = 1'b1;
                res_next.response_time = (reply_elapsed > 32'h0000_FFFF) ?
                                         16'hFFFF : reply_elapsed[15:0];
                res_next.event_res = EV_ACCEPTED;
                current_index_next = adv_index;
                idle_stamp_next = time_now_reg;
                phase_next = PH_IDLE;
            end
        end

        res_next.online_map = online_next;
        res_next.node_index = current_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= POLL_INTERVAL_RESET;
            response_timeout_reg <= RESPONSE_TIMEOUT_RESET;
            node_count_reg <= NODE_COUNT_RESET;
            node_id_table_reg <= NODE_ID_TABLE_RESET;
            pressure_mask_reg <= PRESSURE_MASK_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_POLL_INTERVAL:    poll_interval_reg <= cfg.data[15:0];
                CFG_RESPONSE_TIMEOUT: response_timeout_reg <= cfg.data[15:0];
                CFG_NODE_COUNT:       node_count_reg <= cfg.data[3:0];
                CFG_NODE_ID_TABLE:    node_id_table_reg <= cfg.data;
                CFG_PRESSURE_MASK:    pressure_mask_reg <= cfg.data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            current_index_reg <= 3'd0;
            seq_counter_reg <= 16'd0;
            expected_seq_reg <= 16'd0;
            time_now_reg <= 32'd0;
            idle_stamp_reg <= 32'd0;
            request_stamp_reg <= 32'd0;
            online_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            current_index_reg <= current_index_next;
            seq_counter_reg <= seq_counter_next;
            expected_seq_reg <= expected_seq_next;
            time_now_reg <= time_now_next;
            idle_stamp_reg <= idle_stamp_next;
            request_stamp_reg <= request_stamp_next;
            online_reg <= online_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                inq_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                inq_valid_reg <= 1'b0;
            end
            if (step)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            inq_reg <= cmd.data;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    // A sent request always leaves the master waiting for the reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res_next.event_res == EV_SENT)) |=> (phase_reg == PH_WAIT))
        else $error("request sent without entering the wait phase");

    // An accepted reply always returns the master to idle with its node online.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res_next.event_res == EV_ACCEPTED))
        |=> ((phase_reg == PH_IDLE) && (online_reg == $past(online_next))))
        else $error("accepted reply did not close the poll");

    // The millisecond counter advances by one on every tick event.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (inq_reg.op == OP_TICK)) |=> (time_now_reg == $past(time_now_reg) + 32'd1))
        else $error("tick did not advance the time counter");

    // The sequence counter moves only when a request is issued or refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res_next.event_res != EV_SENT) && (res_next.event_res != EV_TX_ERROR))
        |=> $stable(seq_counter_reg))
        else $error("sequence counter changed without a request");

    // A pending result is never dropped while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !evt.ready) |=> res_valid_reg)
        else $error("stalled result was lost");

endmodule
